@@ hdl/msf_pkg.sv @@
package msf_pkg;

    // offset counter width and tag sizes
    localparam int OFFSET_BITS   = 32;
    localparam int OUT_BITS      = 32;
    localparam int BEGIN_TAG_LEN = 29;
    localparam int END_TAG_LEN   = 30;
    localparam int WIN_LEN       = (BEGIN_TAG_LEN > END_TAG_LEN) ? BEGIN_TAG_LEN : END_TAG_LEN;

    // queue between front and back
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX  = '1;
    localparam logic [OFFSET_BITS-1:0] BEGIN_BACK  = OFFSET_BITS'(BEGIN_TAG_LEN - 1);

    // result kinds
    localparam logic KIND_SPAN   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // end-of-file status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_MARK  = 2'd1;
    localparam logic [1:0] STATUS_ORDER    = 2'd2;

    typedef logic [OFFSET_BITS-1:0] offset_t;
    typedef logic [7:0] window_t [WIN_LEN];

    // open tag bytes
    localparam logic [7:0] BEGIN_TAG [BEGIN_TAG_LEN] = '{
        8'h3C, 8'h70, 8'h68, 8'h6F, 8'h74, 8'h6F, 8'h73, 8'h68, 8'h6F, 8'h70,
        8'h3A, 8'h44, 8'h6F, 8'h63, 8'h75, 8'h6D, 8'h65, 8'h6E, 8'h74, 8'h41,
        8'h6E, 8'h63, 8'h65, 8'h73, 8'h74, 8'h6F, 8'h72, 8'h73, 8'h3E
    };

    // close tag bytes
    localparam logic [7:0] END_TAG [END_TAG_LEN] = '{
        8'h3C, 8'h2F, 8'h70, 8'h68, 8'h6F, 8'h74, 8'h6F, 8'h73, 8'h68, 8'h6F,
        8'h70, 8'h3A, 8'h44, 8'h6F, 8'h63, 8'h75, 8'h6D, 8'h65, 8'h6E, 8'h74,
        8'h41, 8'h6E, 8'h63, 8'h65, 8'h73, 8'h74, 8'h6F, 8'h72, 8'h73, 8'h3E
    };

    // one classified byte, front to back
    typedef struct packed {
        logic    begin_hit;
        logic    end_hit;
        logic    is_last;
        offset_t begin_start;
        offset_t end_after;
    } msf_item_t;

    typedef enum logic {
        BACK_RUN,
        BACK_STATUS
    } back_state_t;

    function automatic logic begin_match(input window_t w);
        logic hit;
        hit = 1'b1;
        for (int i = 0; i < BEGIN_TAG_LEN; i++)
        begin
            if (w[WIN_LEN - BEGIN_TAG_LEN + i] != BEGIN_TAG[i])
            begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

    function automatic logic end_match(input window_t w);
        logic hit;
        hit = 1'b1;
        for (int i = 0; i < END_TAG_LEN; i++)
        begin
            if (w[WIN_LEN - END_TAG_LEN + i] != END_TAG[i])
            begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

endpackage

@@ hdl/msf_front.sv @@
module msf_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    input  logic                is_last,
    output msf_pkg::msf_item_t  item
);

    msf_pkg::window_t window_reg;
    msf_pkg::window_t window_shift;
    msf_pkg::offset_t offset_reg;
    msf_pkg::offset_t offset_next;

    // window as it stands once this byte is in
    always_comb
    begin
        for (int i = 0; i < msf_pkg::WIN_LEN - 1; i++)
        begin
            window_shift[i] = window_reg[i + 1];
        end
        window_shift[msf_pkg::WIN_LEN - 1] = data_byte;
    end

    // saturating offsets
    always_comb
    begin
        offset_next = (offset_reg == msf_pkg::OFFSET_MAX) ? offset_reg
                                                          : offset_reg + 1'b1;
        item.begin_hit   = msf_pkg::begin_match(window_shift);
        item.end_hit     = msf_pkg::end_match(window_shift);
        item.is_last     = is_last;
        item.end_after   = offset_next;
        item.begin_start = (offset_reg >= msf_pkg::BEGIN_BACK)
                         ? offset_reg - msf_pkg::BEGIN_BACK : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            for (int i = 0; i < msf_pkg::WIN_LEN; i++)
            begin
                window_reg[i] <= 8'h00;
            end
        end
        else if (accept)
        begin
            // last byte of a file: start the next file clean
            offset_reg <= is_last ? '0 : offset_next;
            for (int i = 0; i < msf_pkg::WIN_LEN; i++)
            begin
                window_reg[i] <= is_last ? 8'h00 : window_shift[i];
            end
        end
    end

endmodule

@@ hdl/msf_queue.sv @@
module msf_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  msf_pkg::msf_item_t  push_item,
    output logic                full,
    input  logic                pull,
    output msf_pkg::msf_item_t  head_item,
    output logic                empty
);

    msf_pkg::msf_item_t                  items_reg [msf_pkg::QUEUE_DEPTH];
    logic [msf_pkg::QUEUE_PTR_BITS-1:0]  wr_ptr_reg;
    logic [msf_pkg::QUEUE_PTR_BITS-1:0]  rd_ptr_reg;
    logic [msf_pkg::QUEUE_CNT_BITS-1:0]  count_reg;
    logic [msf_pkg::QUEUE_CNT_BITS-1:0]  count_next;

    assign full      = (count_reg == msf_pkg::QUEUE_CNT_BITS'(msf_pkg::QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = items_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pull)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pull)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pull)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            items_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ hdl/msf_back.sv @@
module msf_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  msf_pkg::msf_item_t               head_item,
    input  logic                             empty,
    output logic                             pull,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             result_kind,
    output logic [msf_pkg::OUT_BITS-1:0]     span_start,
    output logic [msf_pkg::OUT_BITS-1:0]     span_end,
    output logic [1:0]                       final_status,
    output logic                             last_of_run
);

    msf_pkg::back_state_t state_reg, state_next;

    // span tracking
    logic             span_open_reg,  span_open_next;
    msf_pkg::offset_t open_start_reg, open_start_next;
    logic             stray_seen_reg, stray_seen_next;
    msf_pkg::offset_t stray_off_reg,  stray_off_next;
    logic             order_err_reg,  order_err_next;
    logic             any_found_reg,  any_found_next;
    logic [1:0]       hold_status_reg, hold_status_next;

    // output register
    logic                          out_valid_reg,    out_valid_next;
    logic                          result_kind_reg,  result_kind_next;
    logic [msf_pkg::OUT_BITS-1:0]  span_start_reg,   span_start_next;
    logic [msf_pkg::OUT_BITS-1:0]  span_end_reg,     span_end_next;
    logic [1:0]                    final_status_reg, final_status_next;
    logic                          last_of_run_reg,  last_of_run_next;

    logic             load_ok;
    logic             closed;
    logic             stray_after;
    msf_pkg::offset_t stray_off_after;
    logic             span_hit;
    msf_pkg::offset_t hit_start;
    msf_pkg::offset_t hit_end;
    logic [1:0]       status_after;

    assign load_ok = !out_valid_reg || out_ready;

    // span rules applied to the head item
    always_comb
    begin
        span_open_next  = span_open_reg;
        open_start_next = open_start_reg;
        stray_seen_next = stray_seen_reg;
        stray_off_next  = stray_off_reg;
        order_err_next  = order_err_reg;
        any_found_next  = any_found_reg;
        closed          = 1'b0;
        span_hit        = 1'b0;
        hit_start       = open_start_reg;
        hit_end         = head_item.end_after;
        stray_after     = stray_seen_reg || (head_item.end_hit && !span_open_reg);
        stray_off_after = stray_seen_reg ? stray_off_reg : head_item.end_after;

        if (!order_err_reg)
        begin
            if (head_item.end_hit && span_open_reg)
            begin
                closed         = 1'b1;
                span_hit       = 1'b1;
                span_open_next = 1'b0;
                any_found_next = 1'b1;
            end
            else if (head_item.end_hit && !stray_seen_reg)
            begin
                stray_seen_next = 1'b1;
                stray_off_next  = head_item.end_after;
            end

            if (!closed && !span_open_reg && head_item.begin_hit)
            begin
                if (stray_after)
                begin
                    if (stray_off_after == head_item.begin_start)
                    begin
                        // begin right where the stray end finished
                        span_hit        = 1'b1;
                        hit_start       = head_item.begin_start;
                        hit_end         = head_item.begin_start;
                        any_found_next  = 1'b1;
                        stray_seen_next = 1'b0;
                        span_open_next  = 1'b1;
                        open_start_next = head_item.begin_start;
                    end
                    else
                    begin
                        order_err_next = 1'b1;
                    end
                end
                else
                begin
                    span_open_next  = 1'b1;
                    open_start_next = head_item.begin_start;
                end
            end
        end

        if (order_err_next)
        begin
            status_after = msf_pkg::STATUS_ORDER;
        end
        else if (any_found_next)
        begin
            status_after = msf_pkg::STATUS_OK;
        end
        else
        begin
            status_after = msf_pkg::STATUS_NO_MARK;
        end
    end

    // sequencing of results onto the output register
    always_comb
    begin
        state_next        = state_reg;
        pull              = 1'b0;
        hold_status_next  = hold_status_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        result_kind_next  = result_kind_reg;
        span_start_next   = span_start_reg;
        span_end_next     = span_end_reg;
        final_status_next = final_status_reg;
        last_of_run_next  = last_of_run_reg;

        case (state_reg)
            msf_pkg::BACK_RUN:
            begin
                if (!empty && (load_ok || (!span_hit && !head_item.is_last)))
                begin
                    pull = 1'b1;
                    if (span_hit)
                    begin
                        out_valid_next    = 1'b1;
                        result_kind_next  = msf_pkg::KIND_SPAN;
                        span_start_next   = msf_pkg::OUT_BITS'(hit_start);
                        span_end_next     = msf_pkg::OUT_BITS'(hit_end);
                        final_status_next = msf_pkg::STATUS_OK;
                        last_of_run_next  = !head_item.is_last;
                        if (head_item.is_last)
                        begin
                            hold_status_next = status_after;
                            state_next       = msf_pkg::BACK_STATUS;
                        end
                    end
                    else if (head_item.is_last)
                    begin
                        out_valid_next    = 1'b1;
                        result_kind_next  = msf_pkg::KIND_STATUS;
                        span_start_next   = '0;
                        span_end_next     = '0;
                        final_status_next = status_after;
                        last_of_run_next  = 1'b1;
                    end
                end
            end
            msf_pkg::BACK_STATUS:
            begin
                if (load_ok)
                begin
                    out_valid_next    = 1'b1;
                    result_kind_next  = msf_pkg::KIND_STATUS;
                    span_start_next   = '0;
                    span_end_next     = '0;
                    final_status_next = hold_status_reg;
                    last_of_run_next  = 1'b1;
                    state_next        = msf_pkg::BACK_RUN;
                end
            end
            default:
            begin
                state_next = msf_pkg::BACK_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= msf_pkg::BACK_RUN;
            out_valid_reg <= 1'b0;
            span_open_reg  <= 1'b0;
            open_start_reg <= '0;
            stray_seen_reg <= 1'b0;
            stray_off_reg  <= '0;
            order_err_reg  <= 1'b0;
            any_found_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (pull)
            begin
                if (head_item.is_last)
                begin
                    // file done: back to reset values
                    span_open_reg  <= 1'b0;
                    open_start_reg <= '0;
                    stray_seen_reg <= 1'b0;
                    stray_off_reg  <= '0;
                    order_err_reg  <= 1'b0;
                    any_found_reg  <= 1'b0;
                end
                else
                begin
                    span_open_reg  <= span_open_next;
                    open_start_reg <= open_start_next;
                    stray_seen_reg <= stray_seen_next;
                    stray_off_reg  <= stray_off_next;
                    order_err_reg  <= order_err_next;
                    any_found_reg  <= any_found_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hold_status_reg  <= hold_status_next;
        result_kind_reg  <= result_kind_next;
        span_start_reg   <= span_start_next;
        span_end_reg     <= span_end_next;
        final_status_reg <= final_status_next;
        last_of_run_reg  <= last_of_run_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = result_kind_reg;
    assign span_start   = span_start_reg;
    assign span_end     = span_end_reg;
    assign final_status = final_status_reg;
    assign last_of_run  = last_of_run_reg;

endmodule

@@ hdl/marker_span_finder.sv @@
// channel   | handshake          | payload
// ----------+--------------------+-----------------------------------------------
// input     | in_valid/in_ready  | data_byte, is_last
// output    | out_valid/out_ready| result_kind, span_start, span_end,
//           |                    | final_status, last_of_run
//
// one byte request per cycle is taken while the queue has room; the tag compare
// happens in the front in the accepting cycle, the span rules in the back
// a byte causing a span and an end-of-file status holds the back until its span and then its status are loaded
// results leave through an output register, so a stalled output only fills the
// four-entry queue before in_ready drops
// rst_n is asynchronous; after reset the window is zero and no span is open
module marker_span_finder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    data_byte,
    input  logic                          is_last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          result_kind,
    output logic [msf_pkg::OUT_BITS-1:0]  span_start,
    output logic [msf_pkg::OUT_BITS-1:0]  span_end,
    output logic [1:0]                    final_status,
    output logic                          last_of_run
);

    msf_pkg::msf_item_t front_item;
    msf_pkg::msf_item_t head_item;
    logic               queue_full;
    logic               queue_empty;
    logic               accept;
    logic               pull;

    // the front never waits on the output side, only on queue space
    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    // window shift, tag compare and offset bookkeeping
    msf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .is_last   (is_last),
        .item      (front_item)
    );

    // classified bytes waiting for the back
    msf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (front_item),
        .full      (queue_full),
        .pull      (pull),
        .head_item (head_item),
        .empty     (queue_empty)
    );

    // span state and result sequencing
    msf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_item    (head_item),
        .empty        (queue_empty),
        .pull         (pull),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_kind  (result_kind),
        .span_start   (span_start),
        .span_end     (span_end),
        .final_status (final_status),
        .last_of_run  (last_of_run)
    );

endmodule

@@ hdl/msf_checker.sv @@
module msf_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic                          result_kind,
    input  logic [msf_pkg::OUT_BITS-1:0]  span_start,
    input  logic [msf_pkg::OUT_BITS-1:0]  span_end,
    input  logic [1:0]                    final_status,
    input  logic                          last_of_run
);

    // a stalled result keeps its valid
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its offsets, status and last_of_run
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(span_start) && $stable(span_end)
                                    && $stable(final_status) && $stable(last_of_run))
        else $error("result changed while stalled");

    // spans carry ok status and never run backwards
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == msf_pkg::KIND_SPAN)
        |-> (final_status == msf_pkg::STATUS_OK) && (span_start <= span_end))
        else $error("bad span result");

    // a status ends its run and carries no offsets
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == msf_pkg::KIND_STATUS)
        |-> last_of_run && (span_start == '0) && (span_end == '0)
            && (final_status <= msf_pkg::STATUS_ORDER))
        else $error("bad status result");

endmodule

bind marker_span_finder msf_checker u_msf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .span_start   (span_start),
    .span_end     (span_end),
    .final_status (final_status),
    .last_of_run  (last_of_run)
);
